[hdl/hsl2rgb_pkg.sv]
// Shared types and constants for the HSL to RGB converter.
package hsl2rgb_pkg;

   // item payloads
   typedef struct packed {
      logic [15:0] hue_scaled;
      logic [15:0] saturation;
      logic [15:0] lightness;
   } hsl_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsl_rsp_type;

   // fixed-point scales
   localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
   localparam int          HUE_PER_DEG = 182;

   // hue / 60 as multiply by reciprocal, exact over 16-bit hue
   localparam int          HP_W            = 11;
   localparam logic [16:0] HUE_DIV60_MUL   = 17'd69906;
   localparam int          HUE_DIV60_SHIFT = 22;

   // product / 182 as multiply by reciprocal, exact below 2^24
   localparam logic [24:0] X_DIV_MUL   = 25'd23598722;
   localparam int          X_DIV_SHIFT = 32;

   // channel / 257 as multiply by reciprocal, exact below 2^24
   localparam logic [16:0] CH_DIV_MUL   = 17'd65281;
   localparam int          CH_DIV_SHIFT = 24;
   localparam logic [9:0]  CH_MAX       = 10'd255;

   // hue sectors
   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;

   // front end -> X generator
   typedef struct packed {
      logic [15:0] chroma;
      logic [15:0] lightness;
      logic [2:0]  sector;
      logic [7:0]  weight;
   } front_out_type;

   // X generator -> output stage
   typedef struct packed {
      logic [15:0] chroma;
      logic [15:0] x_val;
      logic [15:0] offset;
      logic [2:0]  sector;
   } xgen_out_type;

endpackage

[hdl/hsl2rgb_front.sv]
// Chroma and hue sector decode: three register stages.
module hsl2rgb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_hold,
   input  hsl2rgb_pkg::hsl_req_type    in_data,
   output logic                        out_valid,
   input  logic                        out_hold,
   output hsl2rgb_pkg::front_out_type  out_data
);
   import hsl2rgb_pkg::*;

   logic load1, load2, load3;
   logic valid1_ff, valid2_ff, valid3_ff;
   logic valid1_in, valid2_in, valid3_in;

   // stage 1
   logic [16:0]     twol;
   logic [32:0]     hue_prod;
   logic [15:0]     cs1_in, cs1_ff;
   logic [15:0]     sat1_ff, lit1_ff;
   logic [HP_W-1:0] hp1_in, hp1_ff;

   // stage 2
   logic [HP_W-1:0] wrap;
   logic [7:0]      dist_h;
   logic [31:0]     prod2_in, prod2_ff;
   logic [15:0]     lit2_ff;
   logic [2:0]      sector2_in, sector2_ff;
   logic [7:0]      weight2_in, weight2_ff;

   // stage 3
   logic [16:0]     fold;
   logic [15:0]     c3_in, c3_ff;
   logic [15:0]     lit3_ff;
   logic [2:0]      sector3_ff;
   logic [7:0]      weight3_ff;

   // a stage loads when empty or when the next one moves on
   assign load3   = ~valid3_ff | ~out_hold;
   assign load2   = ~valid2_ff | load3;
   assign load1   = ~valid1_ff | load2;
   assign in_hold = ~load1;

   assign valid1_in = load1 ? in_valid  : valid1_ff;
   assign valid2_in = load2 ? valid1_ff : valid2_ff;
   assign valid3_in = load3 ? valid2_ff : valid3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   // 65535 - |2L - 65535|
   always_comb begin
      twol = {in_data.lightness, 1'b0};
      if (twol < 17'(FULL_SCALE)) begin
         cs1_in = twol[15:0];
      end else begin
         cs1_in = 16'(17'd131070 - twol);
      end
   end

   assign hue_prod = 33'(in_data.hue_scaled) * 33'(HUE_DIV60_MUL);
   assign hp1_in   = hue_prod[HUE_DIV60_SHIFT +: HP_W];

   always_ff @(posedge clock) begin
      if (load1) begin
         cs1_ff  <= cs1_in;
         sat1_ff <= in_data.saturation;
         lit1_ff <= in_data.lightness;
         hp1_ff  <= hp1_in;
      end
   end

   assign prod2_in = 32'(cs1_ff) * 32'(sat1_ff);

   // sector and triangle weight 182 - |hp mod 364 - 182|
   always_comb begin
      if (hp1_ff >= HP_W'(5 * HUE_PER_DEG)) begin
         sector2_in = SECTOR_5;
      end else if (hp1_ff >= HP_W'(4 * HUE_PER_DEG)) begin
         sector2_in = SECTOR_4;
      end else if (hp1_ff >= HP_W'(3 * HUE_PER_DEG)) begin
         sector2_in = SECTOR_3;
      end else if (hp1_ff >= HP_W'(2 * HUE_PER_DEG)) begin
         sector2_in = SECTOR_2;
      end else if (hp1_ff >= HP_W'(HUE_PER_DEG)) begin
         sector2_in = SECTOR_1;
      end else begin
         sector2_in = SECTOR_0;
      end

      if (hp1_ff >= HP_W'(6 * HUE_PER_DEG)) begin
         wrap = hp1_ff - HP_W'(6 * HUE_PER_DEG);
      end else if (hp1_ff >= HP_W'(4 * HUE_PER_DEG)) begin
         wrap = hp1_ff - HP_W'(4 * HUE_PER_DEG);
      end else if (hp1_ff >= HP_W'(2 * HUE_PER_DEG)) begin
         wrap = hp1_ff - HP_W'(2 * HUE_PER_DEG);
      end else begin
         wrap = hp1_ff;
      end

      if (wrap >= HP_W'(HUE_PER_DEG)) begin
         dist_h = 8'(wrap - HP_W'(HUE_PER_DEG));
      end else begin
         dist_h = 8'(HP_W'(HUE_PER_DEG) - wrap);
      end
      weight2_in = 8'(HUE_PER_DEG) - dist_h;
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         prod2_ff   <= prod2_in;
         lit2_ff    <= lit1_ff;
         sector2_ff <= sector2_in;
         weight2_ff <= weight2_in;
      end
   end

   // p / 65535: p = q*65536 + r = q*65535 + (q + r), q + r < 2*65535
   assign fold  = {1'b0, prod2_ff[31:16]} + {1'b0, prod2_ff[15:0]};
   assign c3_in = prod2_ff[31:16] + 16'(fold >= 17'(FULL_SCALE));

   always_ff @(posedge clock) begin
      if (load3) begin
         c3_ff      <= c3_in;
         lit3_ff    <= lit2_ff;
         sector3_ff <= sector2_ff;
         weight3_ff <= weight2_ff;
      end
   end

   assign out_valid          = valid3_ff;
   assign out_data.chroma    = c3_ff;
   assign out_data.lightness = lit3_ff;
   assign out_data.sector    = sector3_ff;
   assign out_data.weight    = weight3_ff;

endmodule

[hdl/hsl2rgb_xgen.sv]
// Intermediate X and lightness offset: two register stages.
module hsl2rgb_xgen (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_hold,
   input  hsl2rgb_pkg::front_out_type  in_data,
   output logic                        out_valid,
   input  logic                        out_hold,
   output hsl2rgb_pkg::xgen_out_type   out_data
);
   import hsl2rgb_pkg::*;

   logic load1, load2;
   logic valid1_ff, valid2_ff;
   logic valid1_in, valid2_in;

   logic [15:0] half;
   logic [23:0] px1_in, px1_ff;
   logic [15:0] m1_in, m1_ff;
   logic [15:0] c1_ff;
   logic [2:0]  sector1_ff;

   logic [48:0] xq_prod;
   logic [15:0] x2_in, x2_ff;
   logic [15:0] c2_ff, m2_ff;
   logic [2:0]  sector2_ff;

   assign load2   = ~valid2_ff | ~out_hold;
   assign load1   = ~valid1_ff | load2;
   assign in_hold = ~load1;

   assign valid1_in = load1 ? in_valid  : valid1_ff;
   assign valid2_in = load2 ? valid1_ff : valid2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
   end

   assign px1_in = 24'(in_data.chroma) * 24'(in_data.weight);
   assign half   = {1'b0, in_data.chroma[15:1]};
   assign m1_in  = (in_data.lightness >= half) ? (in_data.lightness - half) : '0;

   always_ff @(posedge clock) begin
      if (load1) begin
         px1_ff     <= px1_in;
         m1_ff      <= m1_in;
         c1_ff      <= in_data.chroma;
         sector1_ff <= in_data.sector;
      end
   end

   // C * weight / 182
   assign xq_prod = 49'(px1_ff) * 49'(X_DIV_MUL);
   assign x2_in   = xq_prod[X_DIV_SHIFT +: 16];

   always_ff @(posedge clock) begin
      if (load2) begin
         x2_ff      <= x2_in;
         c2_ff      <= c1_ff;
         m2_ff      <= m1_ff;
         sector2_ff <= sector1_ff;
      end
   end

   assign out_valid       = valid2_ff;
   assign out_data.chroma = c2_ff;
   assign out_data.x_val  = x2_ff;
   assign out_data.offset = m2_ff;
   assign out_data.sector = sector2_ff;

endmodule

[hdl/hsl2rgb_out.sv]
// Channel placement, offset and 8-bit scaling: two register stages.
module hsl2rgb_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_hold,
   input  hsl2rgb_pkg::xgen_out_type   in_data,
   output logic                        out_valid,
   input  logic                        out_hold,
   output hsl2rgb_pkg::hsl_rsp_type    out_data
);
   import hsl2rgb_pkg::*;

   logic load1, load2;
   logic valid1_ff, valid2_ff;
   logic valid1_in, valid2_in;

   logic [15:0] rv, gv, bv;
   logic [16:0] sum_r_in, sum_g_in, sum_b_in;
   logic [16:0] sum_r_ff, sum_g_ff, sum_b_ff;
   hsl_rsp_type rsp_in, rsp_ff;

   // v / 257, clamped to 255
   function automatic logic [7:0] chan8(input logic [16:0] v);
      logic [33:0] p;
      logic [9:0]  q;
      p = 34'(v) * 34'(CH_DIV_MUL);
      q = p[CH_DIV_SHIFT +: 10];
      chan8 = (q > CH_MAX) ? CH_MAX[7:0] : q[7:0];
   endfunction

   assign load2   = ~valid2_ff | ~out_hold;
   assign load1   = ~valid1_ff | load2;
   assign in_hold = ~load1;

   assign valid1_in = load1 ? in_valid  : valid1_ff;
   assign valid2_in = load2 ? valid1_ff : valid2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
   end

   always_comb begin
      case (in_data.sector)
         SECTOR_0: begin
            rv = in_data.chroma; gv = in_data.x_val;  bv = '0;
         end
         SECTOR_1: begin
            rv = in_data.x_val;  gv = in_data.chroma; bv = '0;
         end
         SECTOR_2: begin
            rv = '0;             gv = in_data.chroma; bv = in_data.x_val;
         end
         SECTOR_3: begin
            rv = '0;             gv = in_data.x_val;  bv = in_data.chroma;
         end
         SECTOR_4: begin
            rv = in_data.x_val;  gv = '0;             bv = in_data.chroma;
         end
         default: begin
            // sector five, and the out-of-range hue top end
            rv = in_data.chroma; gv = '0;             bv = in_data.x_val;
         end
      endcase
      sum_r_in = {1'b0, rv} + {1'b0, in_data.offset};
      sum_g_in = {1'b0, gv} + {1'b0, in_data.offset};
      sum_b_in = {1'b0, bv} + {1'b0, in_data.offset};
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
      end
   end

   assign rsp_in.red   = chan8(sum_r_ff);
   assign rsp_in.green = chan8(sum_g_ff);
   assign rsp_in.blue  = chan8(sum_b_ff);

   always_ff @(posedge clock) begin
      if (load2) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = rsp_ff;

endmodule

[hdl/hsl_to_rgb_converter.sv]
// HSL to 8-bit RGB converter, seven-stage pipeline.
// An accepted req passes through the front end, X generator and output stages to rsp_valid.
// Throughput: one item per cycle while rsp_stall stays low; set by the pipeline, each stage holding one item.
// A stage takes a new item whenever it is empty or its successor moves on.
// Reset (synchronous, active high) empties every stage; the data registers are not reset.
module hsl_to_rgb_converter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  hsl2rgb_pkg::hsl_req_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output hsl2rgb_pkg::hsl_rsp_type  rsp_data
);
   import hsl2rgb_pkg::*;

   // front end: stages 1..3, chroma C and hue sector / weight
   logic          front_valid;
   logic          front_hold;
   front_out_type front_data;

   // X generator: stages 4..5, X = C * weight / 182 and offset m = L - C/2
   logic          xgen_valid;
   logic          xgen_hold;
   xgen_out_type  xgen_data;

   hsl2rgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_hold   (req_stall),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_hold  (front_hold),
      .out_data  (front_data)
   );

   hsl2rgb_xgen u_xgen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_hold   (front_hold),
      .in_data   (front_data),
      .out_valid (xgen_valid),
      .out_hold  (xgen_hold),
      .out_data  (xgen_data)
   );

   // output: stages 6..7, placement by sector, offset, divide by 257;
   // stage 7 is the rsp output register
   hsl2rgb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xgen_valid),
      .in_hold   (xgen_hold),
      .in_data   (xgen_data),
      .out_valid (rsp_valid),
      .out_hold  (rsp_stall),
      .out_data  (rsp_data)
   );

   // the input only backs up once the whole pipe is full and the output waits
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall raised with room in the pipeline");

   // a pipe left empty by reset shows no result in the next cycle
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // an item held between front end and X generator is neither lost nor altered
   assert property (@(posedge clock) disable iff (reset)
      (front_valid && front_hold) |=> (front_valid && $stable(front_data)))
      else $error("held front-end item changed or dropped");

   // same between X generator and output stage
   assert property (@(posedge clock) disable iff (reset)
      (xgen_valid && xgen_hold) |=> (xgen_valid && $stable(xgen_data)))
      else $error("held X-generator item changed or dropped");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the HSL to RGB converter pipeline.
`timescale 1ns / 100ps

module testbench;
   import hsl2rgb_pkg::*;

   // Run limits. The pipeline is seven stages deep, so a short tail after the
   // last result is enough to catch anything spurious that follows it.
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned REPORT_LIMIT = 10;

   // Fixed-point constants of the conversion, kept wide for the predictor.
   localparam logic [63:0] SCALE          = 64'd65535;
   localparam logic [63:0] HUE_STEP       = 64'd182;
   localparam logic [63:0] DEG_PER_SECTOR = 64'd60;
   localparam logic [63:0] CH_DIVISOR     = 64'd257;
   // One sector of hue in input units: 60 degrees of 182 steps each.
   localparam int unsigned SECTOR_SPAN    = 10920;
   localparam int unsigned HUE_LEGAL_MAX  = 65519;

   // Receiver behaviour, changed every so often by the stall process.
   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_PERIODIC
   } flow_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   hsl_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   hsl_rsp_type rsp_data;

   // Predicted colours, oldest first.
   hsl_rsp_type expected_rgb[$];

   int unsigned   cycle_count    = 0;
   int unsigned   error_count    = 0;
   int unsigned   burst_left     = 0;
   int unsigned   sender_max_gap = 0;
   // Hold-off requests from the test sequence, granted by the stall process.
   int unsigned   hold_requests  = 0;
   int unsigned   holds_granted  = 0;
   int unsigned   hold_left      = 0;
   int unsigned   flow_cycle     = 0;
   flow_mode_type flow_mode      = FLOW_FREE;

   hsl_to_rgb_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung pipeline ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d colours outstanding",
                  cycle_count, expected_rgb.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Divide by 257 with truncation, then saturate at 255. The saturation
   // should never act over the input range, but it is part of the spec.
   function automatic logic [7:0] channel_to_8bit(input logic [63:0] level);
      logic [63:0] quotient;
      quotient = level / CH_DIVISOR;
      return (quotient > 64'd255) ? 8'd255 : quotient[7:0];
   endfunction

   function automatic hsl_rsp_type predict_rgb(input hsl_req_type hsl);
      logic [63:0] hue, sat, lum;
      logic [63:0] twice_l, l_dist, chroma;
      logic [63:0] hue_sixths, wrapped, offcentre, x_val;
      logic [63:0] sector, half_chroma, base;
      logic [63:0] r_lvl, g_lvl, b_lvl;
      hsl_rsp_type rgb;
      hue = 64'(hsl.hue_scaled);
      sat = 64'(hsl.saturation);
      lum = 64'(hsl.lightness);

      // chroma = (1 - |2L - 1|) * S, in 16-bit fractions
      twice_l = 64'd2 * lum;
      l_dist  = (twice_l >= SCALE) ? twice_l - SCALE : SCALE - twice_l;
      chroma  = ((SCALE - l_dist) * sat) / SCALE;

      // hue in sixths of a turn (still times 182); X ramps within each pair
      // of sectors, peaking at the sector boundary
      hue_sixths = hue / DEG_PER_SECTOR;
      wrapped    = hue_sixths % (64'd2 * HUE_STEP);
      offcentre  = (wrapped >= HUE_STEP) ? wrapped - HUE_STEP : HUE_STEP - wrapped;
      x_val      = (chroma * (HUE_STEP - offcentre)) / HUE_STEP;
      sector     = hue_sixths / HUE_STEP;

      // sector 6 only arises from a hue of 360 degrees or more; it falls to 5
      case ((sector > 64'd5) ? SECTOR_5 : sector[2:0])
         SECTOR_0: begin r_lvl = chroma; g_lvl = x_val;  b_lvl = 64'd0;  end
         SECTOR_1: begin r_lvl = x_val;  g_lvl = chroma; b_lvl = 64'd0;  end
         SECTOR_2: begin r_lvl = 64'd0;  g_lvl = chroma; b_lvl = x_val;  end
         SECTOR_3: begin r_lvl = 64'd0;  g_lvl = x_val;  b_lvl = chroma; end
         SECTOR_4: begin r_lvl = x_val;  g_lvl = 64'd0;  b_lvl = chroma; end
         default:  begin r_lvl = chroma; g_lvl = 64'd0;  b_lvl = x_val;  end
      endcase

      half_chroma = chroma / 64'd2;
      base        = (lum >= half_chroma) ? lum - half_chroma : 64'd0;

      rgb.red   = channel_to_8bit(r_lvl + base);
      rgb.green = channel_to_8bit(g_lvl + base);
      rgb.blue  = channel_to_8bit(b_lvl + base);
      return rgb;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly legal hue, with a share just past 360 degrees and around the
   // sector boundaries (including the wrap at zero and at the top).
   function automatic logic [15:0] pick_hue(input bit near_edges);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (near_edges || roll < 8)
         return 16'(SECTOR_SPAN * $urandom_range(0, 6) + $urandom_range(0, 2) - 1);
      else if (roll < 14)
         return 16'($urandom_range(HUE_LEGAL_MAX + 1, 65535));
      else if (roll < 22)
         return 16'($urandom());
      else
         return 16'($urandom_range(0, HUE_LEGAL_MAX));
   endfunction

   // Saturation or lightness: full scale, zero, the half point, or anything.
   function automatic logic [15:0] pick_fraction(input bit near_edges);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return 16'd0;
      else if (roll < 16)
         return 16'hFFFF;
      else if (roll < 24 || (near_edges && roll < 50))
         return 16'(32766 + $urandom_range(0, 3));
      else if (near_edges && roll < 70)
         return 16'($urandom_range(0, 3) + (($urandom_range(0, 1) != 0) ? 65532 : 0));
      else
         return 16'($urandom());
   endfunction

   function automatic hsl_req_type random_colour(input bit near_edges);
      hsl_req_type hsl;
      hsl.hue_scaled = pick_hue(near_edges);
      hsl.saturation = pick_fraction(near_edges);
      hsl.lightness  = pick_fraction(near_edges);
      return hsl;
   endfunction

   // Offers one item and waits for it to be taken. Items go out in bursts
   // with random idle gaps between them. Valid stays high on return so that
   // a following call continues the burst without a bubble.
   task automatic send_colour(input hsl_req_type hsl);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data  <= hsl;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      expected_rgb.push_back(predict_rgb(hsl));
   endtask

   task automatic send_hsl(input logic [15:0] hue, input logic [15:0] sat,
                           input logic [15:0] lum);
      hsl_req_type hsl;
      hsl.hue_scaled = hue;
      hsl.saturation = sat;
      hsl.lightness  = lum;
      send_colour(hsl);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Corners of every field, each sector start, the ends of sectors 0 to 3 and 5, and hue past 360.
   task automatic test_directed_extremes();
      sender_max_gap = 3;
      send_hsl(16'd0,     16'd0,     16'd0);      // black
      send_hsl(16'd0,     16'd65535, 16'd65535);  // white, full saturation
      send_hsl(16'd0,     16'd0,     16'd65535);  // white, grey axis
      send_hsl(16'd0,     16'd65535, 16'd0);      // black, full saturation
      send_hsl(16'd0,     16'd65535, 16'd32767);  // pure red, L just below half
      send_hsl(16'd0,     16'd65535, 16'd32768);  // pure red, L just above half
      send_hsl(16'd5460,  16'd65535, 16'd32767);  // mid sector 0
      send_hsl(16'd10919, 16'd65535, 16'd32767);  // last hue of sector 0
      send_hsl(16'd10920, 16'd65535, 16'd32767);  // sector 1 start
      send_hsl(16'd21839, 16'd32768, 16'd49151);
      send_hsl(16'd21840, 16'd65535, 16'd32767);  // sector 2
      send_hsl(16'd32759, 16'd1,     16'd1);
      send_hsl(16'd32760, 16'd65535, 16'd32767);  // sector 3
      send_hsl(16'd43679, 16'd65534, 16'd65534);
      send_hsl(16'd43680, 16'd65535, 16'd32767);  // sector 4
      send_hsl(16'd54600, 16'd65535, 16'd32767);  // sector 5
      send_hsl(16'd65519, 16'd65535, 16'd32767);  // top of legal hue
      send_hsl(16'd65520, 16'd65535, 16'd32767);  // hue past 360, handled as sector 5
      send_hsl(16'd65535, 16'd65535, 16'd32768);  // largest hue code
      send_hsl(16'hAAAA,  16'h5555,  16'hAAAA);   // alternating bits
      send_hsl(16'h5555,  16'hAAAA,  16'h5555);
   endtask

   // Bulk random colours with bursty sending and a shifting receiver.
   task automatic test_random_colours();
      sender_max_gap = 6;
      repeat (700) send_colour(random_colour(1'b0));
   endtask

   // Values clustered on the sector boundaries, the half-lightness fold
   // and the ends of the fraction range.
   task automatic test_boundary_colours();
      sender_max_gap = 2;
      repeat (50) send_colour(random_colour(1'b1));
   endtask

   // Receiver holds off for a long stretch while items keep coming without
   // gaps, so the pipeline fills and must stall its input; done twice.
   task automatic test_output_backpressure();
      sender_max_gap = 0;
      hold_requests++;
      repeat (40) send_colour(random_colour(1'b0));
      hold_requests++;
      repeat (40) send_colour(random_colour(1'b0));
   endtask

   // ---------------------------------------------------------------------
   // Receiver: stall pattern of its own, plus long hold-offs on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      flow_cycle <= flow_cycle + 1;
      if (flow_cycle % 97 == 0)
         flow_mode <= flow_mode_type'($urandom_range(0, 3));
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_granted != hold_requests) begin
         holds_granted <= holds_granted + 1;
         hold_left     <= HOLD_CYCLES - 1;
         rsp_stall     <= 1'b1;
      end else begin
         case (flow_mode)
            FLOW_FREE:     rsp_stall <= 1'b0;
            FLOW_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            FLOW_PERIODIC: rsp_stall <= (flow_cycle % 5 < 2);
            default:       rsp_stall <= 1'b0;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result checking: every colour taken is compared with the oldest
   // prediction, one channel at a time
   // ---------------------------------------------------------------------
   task automatic report_channel(input string channel, input logic [7:0] want,
                                 input logic [7:0] got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0d: %s mismatch, expected %0d got %0d",
                  cycle_count, channel, want, got);
   endtask

   always @(posedge clock) begin
      hsl_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_rgb.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0d: colour %h with no item outstanding",
                        cycle_count, rsp_data);
         end else begin
            want = expected_rgb.pop_front();
            if (rsp_data.red !== want.red)
               report_channel("red", want.red, rsp_data.red);
            if (rsp_data.green !== want.green)
               report_channel("green", want.green, rsp_data.green);
            if (rsp_data.blue !== want.blue)
               report_channel("blue", want.blue, rsp_data.blue);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_random_colours();
      test_boundary_colours();
      test_output_backpressure();
      req_valid <= 1'b0;

      // let the pipeline empty, then watch a while for anything stray
      while (expected_rgb.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
